/* design/cbor_item_validator_unit_defines.svh */
// Assertion macros shared by the validator modules.
`ifndef CBOR_ITEM_VALIDATOR_UNIT_DEFINES_SVH
`define CBOR_ITEM_VALIDATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CIV_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define CIV_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CIV_ASSERT(label, clk, rstn, prop)
`define CIV_ASSERT_NR(label, clk, prop)
`endif
`endif

/* design/civ_pkg.sv */
// Package with the types and constants of the CBOR item validator.
`timescale 1ns / 1ps
package civ_pkg;
    localparam int MaxDepth = 8;
    localparam int LvlW = $clog2(MaxDepth + 2);
    localparam int IdxW = $clog2(MaxDepth + 1);

    localparam logic [3:0] StBusy      = 4'd0;
    localparam logic [3:0] StDone      = 4'd1;
    localparam logic [3:0] StReserved  = 4'd2;
    localparam logic [3:0] StNonShort  = 4'd3;
    localparam logic [3:0] StBadSimple = 4'd4;
    localparam logic [3:0] StStrLong   = 4'd5;
    localparam logic [3:0] StBigCont   = 4'd6;
    localparam logic [3:0] StDeep      = 4'd7;
    localparam logic [3:0] StTrunc     = 4'd8;
    localparam logic [3:0] StBufLong   = 4'd9;

    localparam logic RegMaxBytes = 1'b0;
    localparam logic RegMaxItems = 1'b1;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_OUT
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic pop_more;
    } dp_stat_t;
endpackage

/* design/civ_datapath.sv */
// Datapath of the validator: parse registers, count stack and result register.
`timescale 1ns / 1ps
`include "cbor_item_validator_unit_defines.svh"
module civ_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic [7:0]         in_byte,
    input  logic               end_of_buffer,
    input  civ_pkg::dp_cmd_t   cmd,
    output civ_pkg::dp_stat_t  stat,
    output logic [3:0]         status,
    output logic               buffer_ok,
    output logic               last_result
);
    logic [15:0] max_bytes_reg;
    logic [7:0]  max_items_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [3:0]  ext_size_reg, ext_size_next;
    logic [2:0]  major_reg, major_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] str_left_reg, str_left_next;
    logic [civ_pkg::LvlW-1:0] lvl_reg, lvl_next;
    logic [16:0] cnt_reg, cnt_next;
    logic [3:0]  err_reg, err_next;
    logic        pop_reg, pop_next;
    logic [3:0]  st_reg, st_next;
    logic        ok_reg, ok_next;
    logic        last_out_reg;
    logic [8:0]  stack [civ_pkg::MaxDepth+1];
    logic        push;
    logic [8:0]  push_val;
    logic        dec;
    logic [8:0]  top, top_dec;
    logic        top_valid;

    assign top_valid = (lvl_reg != '0) && (lvl_reg <= civ_pkg::LvlW'(civ_pkg::MaxDepth + 1));
    assign top = top_valid ? stack[civ_pkg::IdxW'(lvl_reg - civ_pkg::LvlW'(1))] : 9'd0;
    assign top_dec = top - 9'd1;
    assign stat.pop_more = pop_next;

    always_comb begin
        logic [4:0]  ai;
        logic [3:0]  st;
        logic [3:0]  err;
        logic        fin;
        logic        hd;
        logic [63:0] v;
        logic [16:0] cnt;
        logic [8:0]  cntc;
        phase_next = phase_reg;
        ext_left_next = ext_left_reg;
        ext_size_next = ext_size_reg;
        major_next = major_reg;
        acc_next = acc_reg;
        str_left_next = str_left_reg;
        lvl_next = lvl_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        pop_next = 1'b0;
        st_next = st_reg;
        ok_next = ok_reg;
        push = 1'b0;
        push_val = '0;
        dec = 1'b0;
        ai = byte_reg[4:0];
        st = civ_pkg::StBusy;
        err = err_reg;
        fin = 1'b0;
        hd = 1'b0;
        v = acc_reg;
        cntc = '0;
        cnt = (cnt_reg != 17'h1FFFF) ? cnt_reg + 17'd1 : cnt_reg;
        if (cmd.exec && !pop_reg) begin
            cnt_next = cnt;
            if (err == '0 && cnt > {1'b0, max_bytes_reg}) begin
                err = civ_pkg::StBufLong;
            end
            if (err == '0) begin
                if (phase_reg == 2'd0) begin
                    if (lvl_reg > civ_pkg::LvlW'(civ_pkg::MaxDepth)) begin
                        st = civ_pkg::StDeep;
                    end else begin
                        major_next = byte_reg[7:5];
                        if (ai >= 5'd28) begin
                            st = civ_pkg::StReserved;
                        end else if (ai < 5'd24) begin
                            v = {59'd0, ai};
                            acc_next = v;
                            hd = 1'b1;
                        end else begin
                            ext_size_next = 4'd1 << ai[1:0];
                            ext_left_next = 4'd1 << ai[1:0];
                            acc_next = '0;
                            phase_next = 2'd1;
                        end
                    end
                end else if (phase_reg == 2'd1) begin
                    v = {acc_reg[55:0], byte_reg};
                    acc_next = v;
                    if (ext_left_reg == 4'd1 || ext_left_reg == 4'd0) begin
                        ext_left_next = 4'd0;
                        phase_next = 2'd0;
                        if ((ext_size_reg == 4'd1 && v < 64'd24) ||
                            (ext_size_reg == 4'd2 && v <= 64'hFF) ||
                            (ext_size_reg == 4'd4 && v <= 64'hFFFF) ||
                            (ext_size_reg == 4'd8 && v <= 64'hFFFF_FFFF)) begin
                            st = civ_pkg::StNonShort;
                        end else begin
                            hd = 1'b1;
                        end
                    end else begin
                        ext_left_next = ext_left_reg - 4'd1;
                    end
                end else begin
                    if (str_left_reg <= 16'd1) begin
                        str_left_next = '0;
                        phase_next = 2'd0;
                        fin = 1'b1;
                    end else begin
                        str_left_next = str_left_reg - 16'd1;
                    end
                end
                if (hd) begin
                    unique case (phase_reg == 2'd0 ? byte_reg[7:5] : major_reg)
                        3'd0, 3'd1: fin = 1'b1;
                        3'd2, 3'd3: begin
                            if (v > {48'd0, max_bytes_reg}) begin
                                st = civ_pkg::StStrLong;
                            end else if (v == 64'd0) begin
                                fin = 1'b1;
                            end else begin
                                str_left_next = v[15:0];
                                phase_next = 2'd2;
                            end
                        end
                        3'd4, 3'd5: begin
                            if (v > {56'd0, max_items_reg}) begin
                                st = civ_pkg::StBigCont;
                            end else begin
                                cntc = ((phase_reg == 2'd0 ? byte_reg[7:5] : major_reg) == 3'd5)
                                    ? {v[7:0], 1'b0} : {1'b0, v[7:0]};
                                if (cntc == '0) begin
                                    fin = 1'b1;
                                end else if (lvl_reg > civ_pkg::LvlW'(civ_pkg::MaxDepth)) begin
                                    st = civ_pkg::StDeep;
                                end else begin
                                    push = 1'b1;
                                    push_val = cntc;
                                    lvl_next = lvl_reg + civ_pkg::LvlW'(1);
                                end
                            end
                        end
                        3'd7: begin
                            if (v == 64'd20 || v == 64'd21) begin
                                fin = 1'b1;
                            end else begin
                                st = civ_pkg::StBadSimple;
                            end
                        end
                        default: st = civ_pkg::StBadSimple;
                    endcase
                end
                if (st >= 4'd2) begin
                    err = st;
                end
            end
            err_next = err;
            st_next = (err != '0) ? err : st;
            if (fin) begin
                if (!top_valid) begin
                    st_next = civ_pkg::StDone;
                end else begin
                    dec = 1'b1;
                    if (top_dec == '0) begin
                        lvl_next = lvl_reg - civ_pkg::LvlW'(1);
                        pop_next = 1'b1;
                    end
                end
            end
        end else if (cmd.exec && pop_reg) begin
            if (!top_valid) begin
                st_next = civ_pkg::StDone;
            end else begin
                dec = 1'b1;
                if (top_dec == '0) begin
                    lvl_next = lvl_reg - civ_pkg::LvlW'(1);
                    pop_next = 1'b1;
                end
            end
        end
        if (cmd.exec && !pop_next) begin
            ok_next = 1'b0;
            if (last_reg) begin
                if (err_next == '0 && (phase_next != 2'd0 || lvl_next != '0)) begin
                    err_next = civ_pkg::StTrunc;
                end
                if (err_next != '0) begin
                    st_next = err_next;
                end
                ok_next = (err_next == '0);
                phase_next = '0;
                ext_left_next = '0;
                ext_size_next = '0;
                major_next = '0;
                acc_next = '0;
                str_left_next = '0;
                lvl_next = '0;
                cnt_next = '0;
                err_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= 16'd1024;
            max_items_reg <= 8'd16;
            phase_reg <= '0;
            ext_left_reg <= '0;
            ext_size_reg <= '0;
            major_reg <= '0;
            acc_reg <= '0;
            str_left_reg <= '0;
            lvl_reg <= '0;
            cnt_reg <= '0;
            err_reg <= '0;
            pop_reg <= 1'b0;
            st_reg <= '0;
            ok_reg <= 1'b0;
            last_out_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == civ_pkg::RegMaxBytes) begin
                max_bytes_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == civ_pkg::RegMaxItems) begin
                max_items_reg <= cfg_wdata[7:0];
            end
            phase_reg <= phase_next;
            ext_left_reg <= ext_left_next;
            ext_size_reg <= ext_size_next;
            major_reg <= major_next;
            acc_reg <= acc_next;
            str_left_reg <= str_left_next;
            lvl_reg <= lvl_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            pop_reg <= pop_next;
            st_reg <= st_next;
            ok_reg <= ok_next;
            if (cmd.exec && !pop_next) begin
                last_out_reg <= last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= in_byte;
            last_reg <= end_of_buffer;
        end
        if (push) begin
            stack[civ_pkg::IdxW'(lvl_reg)] <= push_val;
        end else if (dec) begin
            stack[civ_pkg::IdxW'(lvl_reg - civ_pkg::LvlW'(1))] <= top_dec;
        end
    end

    assign status = st_reg;
    assign buffer_ok = ok_reg;
    assign last_result = last_out_reg;

    `CIV_ASSERT(a_lvl_range, aclk, aresetn, lvl_reg <= civ_pkg::LvlW'(civ_pkg::MaxDepth + 1))
    `CIV_ASSERT(a_ok_clean, aclk, aresetn, ok_reg |-> st_reg == civ_pkg::StDone || st_reg == civ_pkg::StBusy)
    `CIV_ASSERT(a_ok_last, aclk, aresetn, ok_reg |-> last_out_reg)
endmodule

/* design/civ_controller.sv */
// Controller state machine sequencing one request through the datapath.
`timescale 1ns / 1ps
`include "cbor_item_validator_unit_defines.svh"
module civ_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output civ_pkg::dp_cmd_t  cmd,
    input  civ_pkg::dp_stat_t stat
);
    civ_pkg::ctl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            civ_pkg::CTL_IDLE: if (s_valid) state_next = civ_pkg::CTL_EXEC;
            civ_pkg::CTL_EXEC: if (!stat.pop_more) state_next = civ_pkg::CTL_OUT;
            civ_pkg::CTL_OUT:  if (m_ready) state_next = civ_pkg::CTL_IDLE;
            default:           state_next = civ_pkg::CTL_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd = '0;
        unique case (state_reg)
            civ_pkg::CTL_IDLE: begin
                s_ready = 1'b1;
                cmd.load = s_valid;
            end
            civ_pkg::CTL_EXEC: cmd.exec = 1'b1;
            civ_pkg::CTL_OUT:  m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= civ_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CIV_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)
    `CIV_ASSERT(a_excl, aclk, aresetn, !(s_ready && m_valid))
    `CIV_ASSERT(a_load, aclk, aresetn, (s_valid && s_ready) |=> cmd.exec)
endmodule

/* design/cbor_item_validator_unit.sv */
// Top level of the CBOR item validator.
`timescale 1ns / 1ps
// Checks a buffer, one byte per request, for well-formed items of a restricted
// CBOR subset and returns one status result per byte. A byte passes through
// the steps load, execute and output; the execute step repeats for each container
// that the byte closes, since the count stack pops one level per cycle.
// Registers: index 0 max_bytes, index 1 max_container_items.
module cbor_item_validator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic        m_buffer_ok,
    output logic        m_last_result
);
    civ_pkg::dp_cmd_t  cmd;
    civ_pkg::dp_stat_t stat;

    civ_controller u_ctl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat)
    );

    civ_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_byte(s_in_byte), .end_of_buffer(s_end_of_buffer),
        .cmd(cmd), .stat(stat), .status(m_status), .buffer_ok(m_buffer_ok),
        .last_result(m_last_result)
    );
endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the CBOR item validator unit.
`timescale 1ns / 1ps
module testbench;
    localparam int MajUint = 0;
    localparam int MajNint = 1;
    localparam int MajBytes = 2;
    localparam int MajText = 3;
    localparam int MajArray = 4;
    localparam int MajMap = 5;
    localparam int MajSimple = 7;
    localparam int SimpleFalse = 20;
    localparam int SimpleTrue = 21;
    localparam int PhHead = 0;
    localparam int PhExt = 1;
    localparam int PhStr = 2;
    localparam int DrainCycles = 30;
    localparam int StallLimit = 4000;

    typedef struct {
        logic [7:0] data;
        logic       eob;
    } req_t;

    typedef struct {
        logic [3:0] status;
        logic       ok;
        logic       last;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = civ_pkg::RegMaxBytes;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        s_end_of_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic        m_buffer_ok;
    logic        m_last_result;

    req_t       req_q[$];
    logic [7:0] buf_q[$];
    verdict_t   verdict_q[$];
    int         err_cnt = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;

    // Model state of the validator.
    logic [15:0] cur_max_bytes;
    logic [7:0]  cur_max_items;
    int          phase;
    int          ext_left;
    int          ext_len;
    int          major;
    logic [63:0] accum;
    int          str_left;
    int          open_cnt[civ_pkg::MaxDepth + 1];
    int          level;
    int          seen_bytes;
    logic [3:0]  sticky_err;

    cbor_item_validator_unit DUT (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic void clear_model();
        phase = PhHead;
        ext_left = 0;
        ext_len = 0;
        major = 0;
        accum = '0;
        str_left = 0;
        foreach (open_cnt[i]) open_cnt[i] = 0;
        level = 0;
        seen_bytes = 0;
        sticky_err = civ_pkg::StBusy;
    endfunction

    function automatic logic [3:0] close_item();
        forever begin
            if (level == 0 || level > civ_pkg::MaxDepth + 1) return civ_pkg::StDone;
            open_cnt[level - 1]--;
            if (open_cnt[level - 1] != 0) return civ_pkg::StBusy;
            level--;
        end
    endfunction

    function automatic logic [3:0] head_status();
        int n;
        case (major)
            MajUint, MajNint: return close_item();
            MajBytes, MajText: begin
                if (accum > cur_max_bytes) return civ_pkg::StStrLong;
                if (accum == 0) return close_item();
                str_left = int'(accum);
                phase = PhStr;
                return civ_pkg::StBusy;
            end
            MajArray, MajMap: begin
                if (accum > cur_max_items) return civ_pkg::StBigCont;
                n = (major == MajMap) ? 2 * int'(accum) : int'(accum);
                if (n == 0) return close_item();
                if (level > civ_pkg::MaxDepth) return civ_pkg::StDeep;
                open_cnt[level] = n;
                level++;
                return civ_pkg::StBusy;
            end
            MajSimple: begin
                if (accum == SimpleFalse || accum == SimpleTrue) return close_item();
                return civ_pkg::StBadSimple;
            end
            default: return civ_pkg::StBadSimple;
        endcase
    endfunction

    function automatic verdict_t check_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        logic [3:0] st;
        int ai;
        st = civ_pkg::StBusy;
        if (seen_bytes < 'h1FFFF) seen_bytes++;
        if (sticky_err == civ_pkg::StBusy && seen_bytes > cur_max_bytes)
            sticky_err = civ_pkg::StBufLong;
        if (sticky_err == civ_pkg::StBusy) begin
            if (phase == PhHead) begin
                if (level > civ_pkg::MaxDepth) begin
                    st = civ_pkg::StDeep;
                end else begin
                    ai = int'(b[4:0]);
                    major = int'(b[7:5]);
                    if (ai >= 28) begin
                        st = civ_pkg::StReserved;
                    end else if (ai < 24) begin
                        accum = 64'(ai);
                        st = head_status();
                    end else begin
                        ext_len = 1 << (ai - 24);
                        ext_left = ext_len;
                        accum = '0;
                        phase = PhExt;
                    end
                end
            end else if (phase == PhExt) begin
                accum = {accum[55:0], b};
                if (ext_left > 0) ext_left--;
                if (ext_left == 0) begin
                    phase = PhHead;
                    if ((ext_len == 1 && accum < 24) || (ext_len == 2 && accum <= 'hFF) ||
                        (ext_len == 4 && accum <= 'hFFFF) ||
                        (ext_len == 8 && accum <= 'hFFFF_FFFF)) st = civ_pkg::StNonShort;
                    else st = head_status();
                end
            end else begin
                if (str_left > 0) str_left--;
                if (str_left == 0) begin
                    phase = PhHead;
                    st = close_item();
                end
            end
            if (st >= civ_pkg::StReserved) sticky_err = st;
        end
        v.status = (sticky_err != civ_pkg::StBusy) ? sticky_err : st;
        v.ok = 1'b0;
        v.last = last;
        if (last) begin
            if (sticky_err == civ_pkg::StBusy && (phase != PhHead || level != 0))
                sticky_err = civ_pkg::StTrunc;
            if (sticky_err != civ_pkg::StBusy) v.status = sticky_err;
            v.ok = (sticky_err == civ_pkg::StBusy);
            clear_model();
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) verdict_q.push_back(check_byte(s_in_byte, s_end_of_buffer));
            if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_in_byte <= req_q[0].data;
                s_end_of_buffer <= req_q[0].eob;
                void'(req_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no request pending: status %0d", m_status);
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        err_cnt++;
                    end
                    if (m_buffer_ok !== want.ok) begin
                        $error("buffer_ok: expected %0d, got %0d", want.ok, m_buffer_ok);
                        err_cnt++;
                    end
                    if (m_last_result !== want.last) begin
                        $error("last_result: expected %0d, got %0d", want.last, m_last_result);
                        err_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == civ_pkg::RegMaxBytes) cur_max_bytes = val;
        else cur_max_items = val[7:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (req_q.size() > 0 || s_valid || verdict_q.size() > 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic flush_buf();
        req_t r;
        foreach (buf_q[i]) begin
            r.data = buf_q[i];
            r.eob = (i == buf_q.size() - 1);
            req_q.push_back(r);
        end
        buf_q.delete();
    endtask

    task automatic put_head(input int maj, input logic [63:0] val, input bit padded);
        int sz;
        if (val < 24 && !padded) begin
            buf_q.push_back(8'(maj << 5) | val[7:0]);
            return;
        end
        sz = (val < 256) ? 1 : (val < 65536) ? 2 : (val < 64'h1_0000_0000) ? 4 : 8;
        if (padded && sz < 8) sz = sz * 2;
        buf_q.push_back(8'(maj << 5) | 8'(24 + $clog2(sz)));
        for (int i = sz - 1; i >= 0; i--) buf_q.push_back(val[8 * i +: 8]);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(4))
            0: return 64'($urandom_range(23));
            1: return 64'($urandom_range(255, 24));
            2: return 64'($urandom_range(65535, 256));
            3: return {32'd0, $urandom} | 64'h1_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic gen_item(input int lvl);
        int pick;
        int n;
        bit pad;
        pick = $urandom_range(99);
        pad = ($urandom_range(99) < 3);
        if (pick < 30) begin
            put_head($urandom_range(MajNint, MajUint), rand_value(), pad);
        end else if (pick < 50) begin
            n = $urandom_range(6);
            if ($urandom_range(9) == 0 && cur_max_bytes < 40) n = cur_max_bytes + $urandom_range(1);
            put_head($urandom_range(MajText, MajBytes), 64'(n), pad);
            repeat (n) buf_q.push_back(8'($urandom));
        end else if (pick < 62 || lvl > 4 + $urandom_range(5)) begin
            put_head(MajSimple, 64'($urandom_range(SimpleTrue, SimpleFalse)), 1'b0);
        end else begin
            n = $urandom_range(3);
            if ($urandom_range(9) == 0) n = cur_max_items + $urandom_range(1);
            put_head($urandom_range(MajMap, MajArray), 64'(n), pad);
            if (n > 3) n = 3;
            repeat (($urandom_range(1) ? 2 : 1) * n) gen_item(lvl + 1);
        end
    endtask

    task automatic gen_buffer();
        repeat ($urandom_range(3, 1)) gen_item(0);
        case ($urandom_range(19))
            0: buf_q[$urandom_range(buf_q.size() - 1)] = 8'($urandom);
            1: if (buf_q.size() > 1) buf_q.pop_back();
            2: buf_q.push_back(8'($urandom));
            default: ;
        endcase
        flush_buf();
    endtask

    task automatic directed(input logic [7:0] bytes[$]);
        buf_q = bytes;
        flush_buf();
    endtask

    initial begin
        int lim_bytes[8] = '{1024, 0, 65535, 20, 65535, 40, 1024, 300};
        int lim_items[8] = '{16, 255, 0, 3, 255, 2, 16, 8};
        int target;
        cur_max_bytes = 16'd1024;
        cur_max_items = 8'd16;
        clear_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        directed('{8'h00});
        directed('{8'h1b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        directed('{8'h3c});
        directed('{8'h18, 8'h05});
        directed('{8'hf4, 8'hf5});
        directed('{8'hf6});
        directed('{8'hc0, 8'h00});
        directed('{8'h40, 8'h60, 8'h80, 8'ha0, 8'h62, 8'h41, 8'h42});
        directed('{8'ha1, 8'h01, 8'hf5, 8'h59, 8'h04, 8'h01});
        directed('{8'h91});
        directed('{8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h00});
        directed('{8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h00});
        directed('{8'h82, 8'h01});
        directed('{8'hff});
        drain();
        write_reg(civ_pkg::RegMaxBytes, 16'd3);
        directed('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
        drain();

        for (int c = 0; c < 8; c++) begin
            write_reg(civ_pkg::RegMaxBytes, 16'(lim_bytes[c]));
            write_reg(civ_pkg::RegMaxItems, 16'(lim_items[c]));
            case (c % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 79; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 79; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (c == 4) hold_left = 500;
            target = req_q.size() + 75;
            while (req_q.size() < target) gen_buffer();
            drain();
        end

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
